### rtl/hsv_pkg.sv
// shared types and constants for the rgb to hsv converter
// no dependencies; used by every module under rtl
`timescale 1ns / 1ps

package hsv_pkg;

  // component and result widths
  localparam int COMP_BITS = 8;
  localparam int HUE_BITS  = 16;
  localparam int SAT_BITS  = COMP_BITS;

  // hue quotient is at most 2^HUE_BITS/6, so it fits in HUE_BITS-2 bits
  localparam int QH_BITS   = HUE_BITS - 2;
  // hue divisor is 6*spread, at most 6*255
  localparam int HDIV_BITS = COMP_BITS + 3;
  // hue partial remainder stays below the divisor
  localparam int HREM_BITS = HDIV_BITS;

  // quotient bits resolved per divider stage
  localparam int DIV_STEP      = 2;
  localparam int HUE_DIV_STEPS = (QH_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int SAT_DIV_STEPS = (SAT_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_STAGES    = (HUE_DIV_STEPS > SAT_DIV_STEPS) ? HUE_DIV_STEPS
                                                                  : SAT_DIV_STEPS;

  // hue sector bases, one third and two thirds of a turn, truncated
  localparam logic [HUE_BITS-1:0] HUE_THIRD =
    HUE_BITS'((64'd1 << HUE_BITS) / 3);
  localparam logic [HUE_BITS-1:0] HUE_TWO_THIRDS =
    HUE_BITS'(((64'd1 << HUE_BITS) * 2) / 3);

  // which component is largest; red wins ties, then green
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } hsv_sect_t;

  // item traveling through the divider stages
  typedef struct packed {
    hsv_sect_t                  sect;
    logic                       neg;       // hue difference is negative
    logic                       grey;      // spread is zero
    logic [COMP_BITS-1:0]       val;       // largest component
    logic [HDIV_BITS-1:0]       hue_div;   // 6*spread
    logic [HREM_BITS-1:0]       hue_rem;
    logic [QH_BITS-1:0]         hue_q;
    logic [COMP_BITS-1:0]       sat_div;   // same as val
    logic [COMP_BITS-1:0]       sat_rem;
    logic [COMP_BITS-1:0]       sat_low;   // numerator bits not yet shifted in
    logic [SAT_BITS-1:0]        sat_q;
  } hsv_div_t;

endpackage

### rtl/hsv_prep.sv
// front end: max/min search, sector choice, spread and divider operands
// depends on hsv_pkg; two register stages
`timescale 1ns / 1ps

module hsv_prep (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hsv_pkg::COMP_BITS-1:0] red,
  input  logic [hsv_pkg::COMP_BITS-1:0] green,
  input  logic [hsv_pkg::COMP_BITS-1:0] blue,
  output logic                          out_valid,
  input  logic                          out_ready,
  output hsv_pkg::hsv_div_t             out_data
);

  // stage 1 registers
  logic                          s1_vld;
  logic [hsv_pkg::COMP_BITS-1:0] s1_mx;
  logic [hsv_pkg::COMP_BITS-1:0] s1_mn;
  hsv_pkg::hsv_sect_t            s1_sect;
  logic [hsv_pkg::COMP_BITS-1:0] s1_a;
  logic [hsv_pkg::COMP_BITS-1:0] s1_b;

  // stage 2 registers
  logic                          s2_vld;
  hsv_pkg::hsv_div_t             s2_data;

  logic                          s1_rdy;
  logic                          s2_rdy;

  // stage 1 next values
  hsv_pkg::hsv_sect_t            sect_next;
  logic [hsv_pkg::COMP_BITS-1:0] mx_next;
  logic [hsv_pkg::COMP_BITS-1:0] mn_next;
  logic [hsv_pkg::COMP_BITS-1:0] a_next;
  logic [hsv_pkg::COMP_BITS-1:0] b_next;

  // stage 2 arithmetic
  logic [hsv_pkg::COMP_BITS-1:0]   spread;
  logic [hsv_pkg::COMP_BITS-1:0]   mag;
  logic [2*hsv_pkg::COMP_BITS-1:0] sat_num;
  hsv_pkg::hsv_div_t               s2_next;

  assign s2_rdy   = !s2_vld || out_ready;
  assign s1_rdy   = !s1_vld || s2_rdy;
  assign in_ready = s1_rdy;

  always_comb begin
    if (red >= green && red >= blue) begin
      sect_next = hsv_pkg::SECT_RED;
    end else if (green >= blue) begin
      sect_next = hsv_pkg::SECT_GREEN;
    end else begin
      sect_next = hsv_pkg::SECT_BLUE;
    end

    case (sect_next)
      hsv_pkg::SECT_RED: begin
        mx_next = red;
        a_next  = green;
        b_next  = blue;
      end
      hsv_pkg::SECT_GREEN: begin
        mx_next = green;
        a_next  = blue;
        b_next  = red;
      end
      default: begin
        mx_next = blue;
        a_next  = red;
        b_next  = green;
      end
    endcase

    mn_next = red;
    if (green < mn_next) mn_next = green;
    if (blue < mn_next) mn_next = blue;
  end

  always_comb begin
    spread  = s1_mx - s1_mn;
    mag     = (s1_a < s1_b) ? (s1_b - s1_a) : (s1_a - s1_b);
    // spread*255 as a shift and subtract
    sat_num = {spread, {hsv_pkg::COMP_BITS{1'b0}}} - {{hsv_pkg::COMP_BITS{1'b0}}, spread};

    s2_next         = '0;
    s2_next.sect    = s1_sect;
    s2_next.neg     = (s1_a < s1_b);
    s2_next.grey    = (spread == '0);
    s2_next.val     = s1_mx;
    // 6*spread = 4*spread + 2*spread
    s2_next.hue_div = {1'b0, spread, 2'b00} + {2'b00, spread, 1'b0};
    // quotient fits below 2^QH_BITS, so start with mag*2^(HUE_BITS-QH_BITS)
    s2_next.hue_rem = {1'b0, mag, 2'b00};
    s2_next.sat_div = s1_mx;
    s2_next.sat_rem = sat_num[2*hsv_pkg::COMP_BITS-1:hsv_pkg::COMP_BITS];
    s2_next.sat_low = sat_num[hsv_pkg::COMP_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      if (s1_rdy) s1_vld <= in_valid;
      if (s2_rdy) s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_mx   <= mx_next;
      s1_mn   <= mn_next;
      s1_sect <= sect_next;
      s1_a    <= a_next;
      s1_b    <= b_next;
    end
    if (s2_rdy && s1_vld) begin
      s2_data <= s2_next;
    end
  end

  assign out_valid = s2_vld;
  assign out_data  = s2_data;

endmodule

### rtl/hsv_divider.sv
// pipelined restoring dividers for hue and saturation quotients
// depends on hsv_pkg; DIV_STEP quotient bits per stage, both divisions side by side
`timescale 1ns / 1ps

module hsv_divider (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hsv_pkg::hsv_div_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hsv_pkg::hsv_div_t out_data
);

  hsv_pkg::hsv_div_t st  [hsv_pkg::DIV_STAGES];
  logic              vld [hsv_pkg::DIV_STAGES];
  logic              rdy [hsv_pkg::DIV_STAGES+1];

  // resolve the quotient bits that belong to one stage
  function automatic hsv_pkg::hsv_div_t div_stage(input hsv_pkg::hsv_div_t cur,
                                                  input int unsigned stage);
    hsv_pkg::hsv_div_t               nxt;
    logic [hsv_pkg::HREM_BITS:0]     hr;
    logic [hsv_pkg::COMP_BITS:0]     sr;
    nxt = cur;
    for (int j = 0; j < hsv_pkg::DIV_STEP; j++) begin
      if (stage * hsv_pkg::DIV_STEP + j < hsv_pkg::QH_BITS) begin
        hr = {nxt.hue_rem, 1'b0};
        if (hr >= {1'b0, nxt.hue_div}) begin
          hr        = hr - {1'b0, nxt.hue_div};
          nxt.hue_q = {nxt.hue_q[hsv_pkg::QH_BITS-2:0], 1'b1};
        end else begin
          nxt.hue_q = {nxt.hue_q[hsv_pkg::QH_BITS-2:0], 1'b0};
        end
        nxt.hue_rem = hr[hsv_pkg::HREM_BITS-1:0];
      end
      if (stage * hsv_pkg::DIV_STEP + j < hsv_pkg::SAT_BITS) begin
        sr          = {nxt.sat_rem, nxt.sat_low[hsv_pkg::COMP_BITS-1]};
        nxt.sat_low = {nxt.sat_low[hsv_pkg::COMP_BITS-2:0], 1'b0};
        if (sr >= {1'b0, nxt.sat_div}) begin
          sr        = sr - {1'b0, nxt.sat_div};
          nxt.sat_q = {nxt.sat_q[hsv_pkg::SAT_BITS-2:0], 1'b1};
        end else begin
          nxt.sat_q = {nxt.sat_q[hsv_pkg::SAT_BITS-2:0], 1'b0};
        end
        nxt.sat_rem = sr[hsv_pkg::COMP_BITS-1:0];
      end
    end
    return nxt;
  endfunction

  assign rdy[hsv_pkg::DIV_STAGES] = out_ready;

  for (genvar k = 0; k < hsv_pkg::DIV_STAGES; k++) begin : g_stage
    hsv_pkg::hsv_div_t src;
    logic              src_vld;

    if (k == 0) begin : g_first
      assign src     = in_data;
      assign src_vld = in_valid;
    end else begin : g_next
      assign src     = st[k-1];
      assign src_vld = vld[k-1];
    end

    assign rdy[k] = !vld[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_vld) begin
        st[k] <= div_stage(src, k);
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[hsv_pkg::DIV_STAGES-1];
  assign out_data  = st[hsv_pkg::DIV_STAGES-1];

endmodule

### rtl/hsv_finish.sv
// back end: hue sign, sector base, grey and black cases, output register
// depends on hsv_pkg; one register stage
`timescale 1ns / 1ps

module hsv_finish (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  hsv_pkg::hsv_div_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hsv_pkg::HUE_BITS-1:0]  hue,
  output logic [hsv_pkg::SAT_BITS-1:0]  sat,
  output logic [hsv_pkg::COMP_BITS-1:0] val
);

  logic                          vld;
  logic                          rdy;
  logic [hsv_pkg::HUE_BITS-1:0]  term;
  logic [hsv_pkg::HUE_BITS-1:0]  base;
  logic [hsv_pkg::HUE_BITS-1:0]  hue_next;
  logic [hsv_pkg::SAT_BITS-1:0]  sat_next;

  assign rdy      = !vld || out_ready;
  assign in_ready = rdy;

  always_comb begin
    term = {{(hsv_pkg::HUE_BITS-hsv_pkg::QH_BITS){1'b0}}, in_data.hue_q};
    if (in_data.neg) term = '0 - term;

    case (in_data.sect)
      hsv_pkg::SECT_RED:   base = '0;
      hsv_pkg::SECT_GREEN: base = hsv_pkg::HUE_THIRD;
      hsv_pkg::SECT_BLUE:  base = hsv_pkg::HUE_TWO_THIRDS;
      default:             base = '0;
    endcase

    // sum wraps modulo the hue width
    hue_next = in_data.grey ? '0 : (base + term);
    // black pixel divides by zero, result forced to zero
    sat_next = (in_data.val == '0) ? '0 : in_data.sat_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (rdy) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_valid) begin
      hue <= hue_next;
      sat <= sat_next;
      val <= in_data.val;
    end
  end

  assign out_valid = vld;

endmodule

### rtl/rgb_to_hsv_converter.sv
// Converts one 8-bit RGB pixel per transfer into hue, saturation and value. Value is the
// largest component, saturation is spread*255/value (zero for black) and hue is a fraction
// of a full turn scaled by 2^HUE_BITS (zero for grey pixels), with red winning ties, then
// green. With hsv_ready held high the block takes one pixel and gives one result per clock.
// A pixel passes the hsv_prep registers, the divider pipeline resolving DIV_STEP quotient
// bits of the hue and saturation divisions per stage, and the hsv_finish output register.
// Each stage holds its own valid bit and stalls only when it is full and its successor is
// stalled, so bubbles are squeezed out and a stalled result does not block new pixels from
// entering while there is room. Depends on hsv_pkg, hsv_prep, hsv_divider, hsv_finish.
`timescale 1ns / 1ps

module rgb_to_hsv_converter (
  input  logic                          clk,
  input  logic                          rst,
  // pixel channel
  input  logic                          pixel_valid,
  output logic                          pixel_ready,
  input  logic [hsv_pkg::COMP_BITS-1:0] red_in,
  input  logic [hsv_pkg::COMP_BITS-1:0] green_in,
  input  logic [hsv_pkg::COMP_BITS-1:0] blue_in,
  // result channel
  output logic                          hsv_valid,
  input  logic                          hsv_ready,
  output logic [hsv_pkg::HUE_BITS-1:0]  hue_out,
  output logic [hsv_pkg::SAT_BITS-1:0]  sat_out,
  output logic [hsv_pkg::COMP_BITS-1:0] val_out
);

  // front end to divider
  logic              prep_valid;
  logic              prep_ready;
  hsv_pkg::hsv_div_t prep_data;

  // divider to back end
  logic              div_valid;
  logic              div_ready;
  hsv_pkg::hsv_div_t div_data;

  // max/min, sector choice, spread and initial remainders
  hsv_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel_valid),
    .in_ready  (pixel_ready),
    .red       (red_in),
    .green     (green_in),
    .blue      (blue_in),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .out_data  (prep_data)
  );

  // hue and saturation quotients, DIV_STEP bits per stage
  hsv_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_data   (prep_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  // sector base, sign, special cases and the output register
  hsv_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_data   (div_data),
    .out_valid (hsv_valid),
    .out_ready (hsv_ready),
    .hue       (hue_out),
    .sat       (sat_out),
    .val       (val_out)
  );

endmodule

### verif/tb_rgb_to_hsv_converter.sv
// self-checking testbench for rgb_to_hsv_converter: random and corner-case pixels, with
// random gaps on both handshake channels, are checked against an in-bench hsv predictor
// depends on rtl/hsv_pkg.sv and rtl/rgb_to_hsv_converter.sv
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter;

  localparam int CLK_PERIOD   = 8;
  localparam int RST_CYCLES   = 4;
  localparam int MAX_WAIT     = 11;       // longest gap or stall drawn per transfer
  localparam int TAIL_CYCLES  = 3 + hsv_pkg::DIV_STAGES + 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 6;
  localparam int PHASE_PIXELS = 316;

  // one pixel waiting to be sent, with its lead-in gap
  typedef struct {
    logic [hsv_pkg::COMP_BITS-1:0] red;
    logic [hsv_pkg::COMP_BITS-1:0] green;
    logic [hsv_pkg::COMP_BITS-1:0] blue;
    int                            gap;
    bit                            drain;   // hold off until every pending result is back
  } pixel_item_t;

  typedef struct packed {
    hsv_pkg::hsv_sect_t            sect;
    logic [hsv_pkg::HUE_BITS-1:0]  hue;
    logic [hsv_pkg::SAT_BITS-1:0]  sat;
    logic [hsv_pkg::COMP_BITS-1:0] val;
  } hsv_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          pixel_valid = 1'b0;
  logic                          pixel_ready;
  logic [hsv_pkg::COMP_BITS-1:0] red_in = '0;
  logic [hsv_pkg::COMP_BITS-1:0] green_in = '0;
  logic [hsv_pkg::COMP_BITS-1:0] blue_in = '0;
  logic                          hsv_valid;
  logic                          hsv_ready = 1'b0;
  logic [hsv_pkg::HUE_BITS-1:0]  hue_out;
  logic [hsv_pkg::SAT_BITS-1:0]  sat_out;
  logic [hsv_pkg::COMP_BITS-1:0] val_out;

  pixel_item_t pixel_feed[$];
  int          stall_plan[$];     // receiver stall after each result
  hsv_result_t expected_hsv[$];

  int err_cnt = 0;
  int pixels_sent = 0;
  int results_checked = 0;
  int grey_cnt = 0;
  int black_cnt = 0;
  int sect_cnt[3] = '{0, 0, 0};
  int cycle_cnt = 0;
  int gap_cnt = 0;
  int rx_wait = 0;

  rgb_to_hsv_converter dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .red_in      (red_in),
    .green_in    (green_in),
    .blue_in     (blue_in),
    .hsv_valid   (hsv_valid),
    .hsv_ready   (hsv_ready),
    .hue_out     (hue_out),
    .sat_out     (sat_out),
    .val_out     (val_out)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // hue, saturation and value of one pixel, all integer arithmetic
  function automatic hsv_result_t compute_hsv(input logic [hsv_pkg::COMP_BITS-1:0] r,
                                              input logic [hsv_pkg::COMP_BITS-1:0] g,
                                              input logic [hsv_pkg::COMP_BITS-1:0] b);
    hsv_result_t res;
    int          mx;
    int          mn;
    int          spread;
    int          diff;
    int          sat_full;
    longint      turn;
    longint      base;
    longint      quot;
    longint      hue_sum;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    spread = mx - mn;
    turn = longint'(1) << hsv_pkg::HUE_BITS;
    // sector choice: red wins ties, then green
    if (mx == r) begin
      res.sect = hsv_pkg::SECT_RED;
      base = 0;
      diff = int'(g) - int'(b);
    end else if (mx == g) begin
      res.sect = hsv_pkg::SECT_GREEN;
      base = turn / 3;
      diff = int'(b) - int'(r);
    end else begin
      res.sect = hsv_pkg::SECT_BLUE;
      base = (turn * 2) / 3;
      diff = int'(r) - int'(g);
    end
    hue_sum = 0;
    if (spread != 0) begin
      // magnitude first so the division truncates toward zero
      quot = (longint'(diff < 0 ? -diff : diff) << hsv_pkg::HUE_BITS) /
             longint'(6 * spread);
      hue_sum = base + ((diff < 0) ? -quot : quot);
    end
    sat_full = (mx == 0) ? 0 : (spread * 255) / mx;
    res.hue = hue_sum[hsv_pkg::HUE_BITS-1:0];   // negative sums wrap into the top of the range
    res.sat = sat_full[hsv_pkg::SAT_BITS-1:0];
    res.val = mx[hsv_pkg::COMP_BITS-1:0];
    return res;
  endfunction

  task automatic add_pixel(input int r, input int g, input int b, input int gap_max,
                           input int stall_max, input bit drain);
    pixel_item_t item;
    item.red   = r[hsv_pkg::COMP_BITS-1:0];
    item.green = g[hsv_pkg::COMP_BITS-1:0];
    item.blue  = b[hsv_pkg::COMP_BITS-1:0];
    item.gap   = $urandom_range(0, gap_max);
    item.drain = drain;
    pixel_feed.push_back(item);
    stall_plan.push_back($urandom_range(0, stall_max));
  endtask

  function automatic int pick_component(input int kind, input int base);
    int v;
    case (kind)
      0: v = $urandom_range(0, 255);
      1: begin
        // near grey, small spreads stress the hue divider
        v = base + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      default: begin
        case ($urandom_range(0, 2))
          0: v = 0;
          1: v = 255;
          default: v = $urandom_range(0, 255);
        endcase
      end
    endcase
    return v;
  endfunction

  // sender: presents queued pixels, records the expectation on each transfer
  always @(posedge clk) begin : pixel_driver
    logic        nxt_valid;
    pixel_item_t item;
    hsv_result_t res;
    if (rst) begin
      pixel_valid <= 1'b0;
      gap_cnt = 0;
    end else begin
      nxt_valid = pixel_valid;
      if (pixel_valid && pixel_ready) begin
        res = compute_hsv(red_in, green_in, blue_in);
        expected_hsv.push_back(res);
        pixels_sent++;
        sect_cnt[res.sect]++;
        if (res.val == 0) black_cnt++;
        else if (res.sat == 0) grey_cnt++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pixel_feed.size() > 0) begin
        if (pixel_feed[0].drain && expected_hsv.size() > 0) begin
          // hold off until the pipeline has emptied
        end else if (gap_cnt < pixel_feed[0].gap) begin
          gap_cnt++;
        end else begin
          item = pixel_feed.pop_front();
          red_in   <= item.red;
          green_in <= item.green;
          blue_in  <= item.blue;
          nxt_valid = 1'b1;
          gap_cnt = 0;
        end
      end
      pixel_valid <= nxt_valid;
    end
  end

  // receiver: random stalls on ready, compares each transfer with the oldest expectation
  always @(posedge clk) begin : hsv_monitor
    hsv_result_t exp_res;
    if (rst) begin
      hsv_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (hsv_valid && hsv_ready) begin
        if (expected_hsv.size() == 0) begin
          $error("unexpected result: hue_out %0d sat_out %0d val_out %0d",
                 hue_out, sat_out, val_out);
          err_cnt++;
        end else begin
          exp_res = expected_hsv.pop_front();
          results_checked++;
          if (hue_out !== exp_res.hue) begin
            $error("hue_out mismatch: expected %0d, got %0d", exp_res.hue, hue_out);
            err_cnt++;
          end
          if (sat_out !== exp_res.sat) begin
            $error("sat_out mismatch: expected %0d, got %0d", exp_res.sat, sat_out);
            err_cnt++;
          end
          if (val_out !== exp_res.val) begin
            $error("val_out mismatch: expected %0d, got %0d", exp_res.val, val_out);
            err_cnt++;
          end
        end
        rx_wait = (stall_plan.size() > 0) ? stall_plan.pop_front() : 0;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      hsv_ready <= (rx_wait == 0);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               expected_hsv.size());
      $display("tb_rgb_to_hsv_converter NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int gap_max[PHASES];
    int stall_max[PHASES];
    int kind;
    int base;
    int r;
    int g;
    int b;

    gap_max   = '{0, MAX_WAIT, 0, MAX_WAIT, 3, MAX_WAIT};
    stall_max = '{0, 0, MAX_WAIT, MAX_WAIT, 3, 2};

    // corners: black, white, primaries, ties, grey, wrap below zero, tiny spreads
    add_pixel(0, 0, 0, 0, 0, 1'b0);
    add_pixel(255, 255, 255, 0, 0, 1'b0);
    add_pixel(255, 0, 0, 0, 0, 1'b0);
    add_pixel(0, 255, 0, 0, 0, 1'b0);
    add_pixel(0, 0, 255, 0, 0, 1'b0);
    add_pixel(255, 255, 0, 0, 0, 1'b0);
    add_pixel(0, 255, 255, 0, 0, 1'b0);
    add_pixel(255, 0, 255, 0, 0, 1'b0);
    add_pixel(128, 128, 128, 0, 0, 1'b0);
    add_pixel(1, 1, 1, 0, 0, 1'b0);
    add_pixel(255, 0, 1, 0, 0, 1'b0);
    add_pixel(255, 0, 128, 0, 0, 1'b0);
    add_pixel(1, 0, 0, 0, 0, 1'b0);
    add_pixel(0, 1, 0, 0, 0, 1'b0);
    add_pixel(0, 0, 1, 0, 0, 1'b0);
    add_pixel(1, 0, 1, 0, 0, 1'b0);
    add_pixel(254, 255, 255, 0, 0, 1'b0);
    add_pixel(255, 254, 255, 0, 0, 1'b0);
    add_pixel(85, 170, 255, 0, 0, 1'b0);
    add_pixel(255, 1, 0, 0, 0, 1'b0);
    add_pixel(10, 20, 30, 0, 0, 1'b0);
    add_pixel(200, 100, 150, 0, 0, 1'b0);
    add_pixel(100, 200, 50, 0, 0, 1'b0);

    // random phases, each opens by letting the pipeline run dry
    for (int p = 0; p < PHASES; p++) begin
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        kind = $urandom_range(0, 3);
        base = $urandom_range(0, 255);
        r = pick_component(kind, base);
        g = pick_component(kind, base);
        b = pick_component(kind, base);
        if (kind == 3) begin
          // force a tie between two components
          case ($urandom_range(0, 2))
            0: g = r;
            1: b = r;
            default: b = g;
          endcase
        end
        add_pixel(r, g, b, gap_max[p], stall_max[p], i == 0);
      end
    end

    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (pixel_feed.size() > 0 || pixel_valid || expected_hsv.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("checked %0d results for %0d pixels in %0d cycles", results_checked,
             pixels_sent, cycle_cnt);
    $display("sectors red/green/blue %0d/%0d/%0d, grey %0d, black %0d",
             sect_cnt[hsv_pkg::SECT_RED], sect_cnt[hsv_pkg::SECT_GREEN],
             sect_cnt[hsv_pkg::SECT_BLUE], grey_cnt, black_cnt);
    if (err_cnt == 0 && expected_hsv.size() == 0 && results_checked == pixels_sent) begin
      $display("tb_rgb_to_hsv_converter OK");
    end else begin
      $display("tb_rgb_to_hsv_converter NOT OK");
    end
    $finish;
  end

endmodule

### rgb_to_hsv_converter.f
rtl/hsv_pkg.sv
rtl/hsv_prep.sv
rtl/hsv_divider.sv
rtl/hsv_finish.sv
rtl/rgb_to_hsv_converter.sv
verif/tb_rgb_to_hsv_converter.sv
